### rtl/sflms_pkg.sv
// Package for the shared free-list multi-stack block.
// Holds default sizes, operation codes, word layout and the controller state type.
// No dependencies.
package sflms_pkg;

   localparam int NUM_STACKS_DEF  = 8;
   localparam int STORE_DEPTH_DEF = 1024;
   localparam int DATA_WIDTH_DEF  = 32;

   // Fixed field widths of the stream words
   localparam int SEL_W       = 3;
   localparam int VALUE_W     = 32;
   localparam int REQ_TDATA_W = 40;   // sel + value, padded to whole bytes
   localparam int RSP_TDATA_W = 32;

   // Operation codes carried on req_tuser
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

### rtl/shared_free_list_multi_stack.sv
// Shared free-list multi-stack: several LIFO stacks kept in one data store.
// Depends on sflms_pkg for defaults, operation codes and the state type.
//
// Usage
//   Request channel (req_*): one word per operation. req_tuser is the kind
//   (push or pop), req_tdata carries the stack number and the value to push.
//   Response channel (rsp_*): exactly one word per request, in order.
//   rsp_tuser is the ok flag; rsp_tdata is the popped value, zero for every
//   push and for every failed operation.
//   A request is taken in ST_IDLE and executed in ST_EXEC, where its response
//   is registered as soon as the response register is free.
//   Operations do not overlap. Acceptance in ST_IDLE reads the link
//   and data stores at the free head or the selected stack head; ST_EXEC
//   updates the free head or stack head that the following operation reads.
//   Reset: every stack empty, free list runs 0, 1, 2 and so on. No clearing
//   pass: a fill counter marks how far the store has been touched, and an
//   untouched entry reads as linking to its successor.
//   Stall: while a response waits unaccepted, one more request may be taken
//   and read; its update then holds until the response register is freed.
//   A push into a full store, a pop of an empty stack and a stack number at
//   or beyond NUM_STACKS return ok low and change nothing.
module shared_free_list_multi_stack #(
   parameter int NUM_STACKS  = sflms_pkg::NUM_STACKS_DEF,
   parameter int STORE_DEPTH = sflms_pkg::STORE_DEPTH_DEF,
   parameter int DATA_WIDTH  = sflms_pkg::DATA_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sflms_pkg::REQ_TDATA_W-1:0] req_tdata,  // [2:0] stack_sel, [34:3] push_value
   input  logic                             req_tuser,  // [0] kind
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sflms_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [31:0] pop_value
   output logic                             rsp_tuser   // [0] ok
);

   // Link values reach STORE_DEPTH, which stands for the null link
   localparam int LINK_W = $clog2(STORE_DEPTH + 1);
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int HIDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(STORE_DEPTH);

   // Stores: no reset, data undefined until pushed
   logic [DATA_WIDTH-1:0] data_mem [STORE_DEPTH];
   logic [LINK_W-1:0]     link_mem [STORE_DEPTH];

   sflms_pkg::state_type state_ff, state_in;

   logic                  op_kind_ff;
   logic [HIDX_W-1:0]     op_sel_ff;
   logic                  op_range_ff;
   logic [DATA_WIDTH-1:0] op_value_ff;
   logic [LINK_W-1:0]     slot_ff;
   logic [LINK_W-1:0]     rd_link_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic [LINK_W-1:0]     free_head_ff, free_head_in;
   logic [LINK_W-1:0]     fill_ff, fill_in;
   logic [LINK_W-1:0]     stack_head_ff [NUM_STACKS];

   logic                  rsp_valid_ff, rsp_ok_ff;
   logic [sflms_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   // request decode
   logic [sflms_pkg::SEL_W-1:0]   req_sel;
   logic [sflms_pkg::VALUE_W-1:0] req_value;
   logic [HIDX_W-1:0]             req_idx;
   logic                          req_range;
   logic [LINK_W-1:0]             req_slot;
   logic                          req_fire;

   // execute-cycle signals
   logic                  out_free;
   logic                  exec_fire;
   logic                  slot_null;
   logic                  op_ok;
   logic [LINK_W-1:0]     next_link;
   logic [LINK_W-1:0]     sel_head;
   logic [ADDR_W-1:0]     slot_addr;

   assign req_sel   = req_tdata[sflms_pkg::SEL_W-1:0];
   assign req_value = req_tdata[sflms_pkg::SEL_W +: sflms_pkg::VALUE_W];
   assign req_idx   = HIDX_W'(req_sel);
   assign req_range = 7'(req_sel) < 7'(NUM_STACKS);
   // a pop starts at the stack top, a push at the free head
   assign req_slot  = (req_tuser == sflms_pkg::KIND_POP) ? stack_head_ff[req_idx] : free_head_ff;
   assign req_fire  = req_tvalid && req_tready;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign exec_fire = (state_ff == sflms_pkg::ST_EXEC) && out_free;

   assign slot_null = slot_ff >= LINK_NULL;
   assign op_ok     = op_range_ff && !slot_null;
   assign sel_head  = stack_head_ff[op_sel_ff];
   assign slot_addr = slot_ff[ADDR_W-1:0];
   // entries at or beyond the fill mark were never written and still link onward
   assign next_link = (slot_ff >= fill_ff) ? LINK_W'(slot_ff + 1'b1) : rd_link_ff;

   // ---------------- controller ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sflms_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = sflms_pkg::ST_EXEC;
         end
         sflms_pkg::ST_EXEC: begin
            if (out_free) state_in = sflms_pkg::ST_IDLE;
         end
         default: state_in = sflms_pkg::ST_IDLE;
      endcase
   end

   // take no word while reset is held
   always_comb begin
      req_tready = 1'b0;
      case (state_ff)
         sflms_pkg::ST_IDLE: req_tready = !reset;
         sflms_pkg::ST_EXEC: req_tready = 1'b0;
         default:            req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sflms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- capture the operation and read the stores ----------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_kind_ff  <= req_tuser;
         op_sel_ff   <= req_idx;
         op_range_ff <= req_range;
         op_value_ff <= DATA_WIDTH'(req_value);
         slot_ff     <= req_slot;
         rd_link_ff  <= link_mem[req_slot[ADDR_W-1:0]];
         rd_data_ff  <= data_mem[req_slot[ADDR_W-1:0]];
      end
   end

   // write the stores on a successful operation
   always_ff @(posedge clock) begin
      if (exec_fire && op_ok) begin
         if (op_kind_ff == sflms_pkg::KIND_PUSH) begin
            data_mem[slot_addr] <= op_value_ff;
            link_mem[slot_addr] <= sel_head;
         end else begin
            link_mem[slot_addr] <= free_head_ff;
         end
      end
   end

   // ---------------- list heads ----------------
   always_comb begin
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      if (exec_fire && op_ok) begin
         if (op_kind_ff == sflms_pkg::KIND_PUSH) begin
            free_head_in = next_link;
            if (slot_ff == fill_ff) fill_in = LINK_W'(fill_ff + 1'b1);
         end else begin
            free_head_in = slot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         fill_ff      <= '0;
         for (int i = 0; i < NUM_STACKS; i++) begin
            stack_head_ff[i] <= LINK_NULL;
         end
      end else begin
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         if (exec_fire && op_ok) begin
            // push makes the slot the new top, pop drops to the next entry
            stack_head_ff[op_sel_ff] <=
               (op_kind_ff == sflms_pkg::KIND_PUSH) ? slot_ff : next_link;
         end
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_ok_ff   <= op_ok;
         rsp_data_ff <= (op_ok && op_kind_ff == sflms_pkg::KIND_POP) ?
                        sflms_pkg::RSP_TDATA_W'(rd_data_ff) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LINK_NULL)
      else $error("fill mark beyond store depth");

   a_free_below_fill: assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= fill_ff)
      else $error("free head points past the touched region");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_data_ff == '0)
      else $error("failed operation returned non-zero data");

   a_two_cycle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request taken in back-to-back cycles");

   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid_ff && state_ff == sflms_pkg::ST_IDLE)
      else $error("executed operation left no response");

endmodule
